/* hdl/hes_pkg.sv */
// hes_pkg: shared types, codes and helpers for the heston euler path step block
// no dependencies; imported by hes_ctrl, hes_dp, the top level and the checker
`default_nettype none

package hes_pkg;

    // dt and sqrt(dt) in q0.32
    localparam logic [18:0] DT_Q32  = 19'd429497;
    localparam logic [25:0] SDT_Q32 = 26'd42949673;

    localparam logic [47:0] CAP_POS = 48'h7FFF_FFFF_FFFF;
    localparam logic [47:0] CAP_NEG = 48'h8000_0000_0000;

    typedef enum logic [1:0] {
        OP_LOAD_SEG,
        OP_LOAD_OBS,
        OP_START,
        OP_STEP
    } opcode_t;

    typedef enum logic [2:0] {
        CFG_SPOT,
        CFG_INIT_VAR,
        CFG_KAPPA,
        CFG_RHO,
        CFG_RHO_COMP,
        CFG_MODE,
        CFG_SEG_CNT,
        CFG_OBS_CNT
    } cfg_idx_t;

    // products computed on the shared multiplier, in issue order
    typedef enum logic [3:0] {
        MUL_SQDT,
        MUL_RN1,
        MUL_RCN2,
        MUL_KAP,
        MUL_DT,
        MUL_SZ,
        MUL_XI,
        MUL_SN1,
        MUL_S,
        MUL_FWD
    } mul_sel_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SEG,
        ST_SQRT,
        ST_MUL,
        ST_MWAIT,
        ST_UPD,
        ST_PEAK,
        ST_DIV,
        ST_DWAIT,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic     seg_adv;
        logic     sqrt_start;
        logic     mul_start;
        mul_sel_t mul_sel;
        logic     div_start;
        logic     update;
        logic     peak;
        logic     step_inc;
        logic     emit;
    } cmd_t;

    typedef struct packed {
        logic path_done;
        logic sqrt_done;
        logic mul_done;
        logic div_done;
        logic obs_hit;
        logic out_full;
    } sts_t;

    function automatic mul_sel_t next_sel(mul_sel_t s);
        mul_sel_t n;
        unique case (s)
            MUL_SQDT: n = MUL_RN1;
            MUL_RN1:  n = MUL_RCN2;
            MUL_RCN2: n = MUL_KAP;
            MUL_KAP:  n = MUL_DT;
            MUL_DT:   n = MUL_SZ;
            MUL_SZ:   n = MUL_XI;
            MUL_XI:   n = MUL_SN1;
            MUL_SN1:  n = MUL_S;
            default:  n = MUL_FWD;
        endcase
        return n;
    endfunction

    // magnitude of a 48-bit signed word, as unsigned
    function automatic logic [47:0] mag48(logic [47:0] x);
        return x[47] ? (~x + 48'd1) : x;
    endfunction

    // 49-bit signed sum saturated to 48-bit signed
    function automatic logic [47:0] sat49(logic [48:0] x);
        logic [47:0] r;
        if (x[48] != x[47]) begin
            r = x[48] ? CAP_NEG : CAP_POS;
        end else begin
            r = x[47:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

/* hdl/hes_ctrl.sv */
// hes_ctrl: sequencer for one time step (sqrt, product chain, update, divide, emit)
// depends on hes_pkg; drives hes_dp through cmd_t and reads sts_t
`default_nettype none

module hes_ctrl (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    input  wire logic [1:0]    s_opcode,
    output logic               s_ready,
    input  hes_pkg::sts_t      sts,
    output hes_pkg::cmd_t      cmd
);
    import hes_pkg::*;

    state_t   state_reg, state_next;
    mul_sel_t sel_reg, sel_next;

    // state and product select registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            sel_reg   <= MUL_SQDT;
        end else begin
            state_reg <= state_next;
            sel_reg   <= sel_next;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        sel_next   = sel_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid && s_opcode == OP_STEP && !sts.path_done) begin
                    state_next = ST_SEG;
                end
            end
            ST_SEG: begin
                sel_next   = MUL_SQDT;
                state_next = ST_SQRT;
            end
            ST_SQRT: begin
                if (sts.sqrt_done) state_next = ST_MUL;
            end
            ST_MUL: begin
                state_next = ST_MWAIT;
            end
            ST_MWAIT: begin
                if (sts.mul_done) begin
                    priority if (sel_reg == MUL_S) begin
                        state_next = ST_UPD;
                    end else if (sel_reg == MUL_FWD) begin
                        state_next = ST_DIV;
                    end else begin
                        sel_next   = next_sel(sel_reg);
                        state_next = ST_MUL;
                    end
                end
            end
            ST_UPD: begin
                state_next = ST_PEAK;
            end
            ST_PEAK: begin
                if (sts.obs_hit) begin
                    sel_next   = MUL_FWD;
                    state_next = ST_MUL;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_DIV: begin
                state_next = ST_DWAIT;
            end
            ST_DWAIT: begin
                if (sts.div_done) state_next = ST_OUT;
            end
            ST_OUT: begin
                if (!sts.out_full) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // commands
    always_comb begin
        cmd         = '0;
        cmd.mul_sel = sel_reg;
        s_ready     = 1'b0;
        unique case (state_reg)
            ST_IDLE:  s_ready = 1'b1;
            ST_SEG: begin
                cmd.seg_adv    = 1'b1;
                cmd.sqrt_start = 1'b1;
            end
            ST_MUL:   cmd.mul_start = 1'b1;
            ST_UPD:   cmd.update    = 1'b1;
            ST_PEAK: begin
                cmd.peak     = 1'b1;
                cmd.step_inc = !sts.obs_hit;
            end
            ST_DIV:   cmd.div_start = 1'b1;
            ST_OUT: begin
                cmd.emit     = !sts.out_full;
                cmd.step_inc = !sts.out_full;
            end
            default: ;
        endcase
    end

endmodule

`default_nettype wire

/* hdl/hes_dp.sv */
// hes_dp: config registers, tables, path state, sqrt unit, shared multiplier,
// divider and output register; depends on hes_pkg, controlled by hes_ctrl
`default_nettype none

module hes_dp #(
    parameter int MAX_SEGMENTS     = 16,
    parameter int MAX_OBSERVATIONS = 64
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                cfg_wr_en,
    input  wire logic [2:0]          cfg_index,
    input  wire logic [46:0]         cfg_data,
    input  wire logic                s_accept,
    input  wire logic [1:0]          s_opcode,
    input  wire logic [5:0]          s_table_index,
    input  wire logic [23:0]         s_bound_step,
    input  wire logic signed [47:0]  s_table_value,
    input  wire logic signed [31:0]  s_segment_volvol,
    input  wire logic signed [31:0]  s_normal_first,
    input  wire logic signed [31:0]  s_normal_second,
    input  hes_pkg::cmd_t            cmd,
    output hes_pkg::sts_t            sts,
    input  wire logic                m_ready,
    output logic                     m_valid,
    output logic [5:0]               m_observation_index,
    output logic signed [47:0]       m_path_value,
    output logic                     m_last
);
    import hes_pkg::*;

    localparam int SAW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
    localparam int OAW = (MAX_OBSERVATIONS > 1) ? $clog2(MAX_OBSERVATIONS) : 1;
    localparam int OPW = $clog2(MAX_OBSERVATIONS + 1);

    // configuration registers
    logic [46:0]        spot_reg;
    logic [30:0]        ivar_reg, kappa_reg;
    logic signed [25:0] rho_reg;
    logic [24:0]        rc_reg;
    logic               mode_reg;
    logic [4:0]         segcnt_reg;
    logic [6:0]         obscnt_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            spot_reg   <= 47'd16777216;
            ivar_reg   <= '0;
            kappa_reg  <= '0;
            rho_reg    <= '0;
            rc_reg     <= 25'd16777216;
            mode_reg   <= 1'b0;
            segcnt_reg <= 5'd1;
            obscnt_reg <= 7'd1;
        end else if (cfg_wr_en) begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_SPOT:     spot_reg   <= cfg_data;
                CFG_INIT_VAR: ivar_reg   <= cfg_data[30:0];
                CFG_KAPPA:    kappa_reg  <= cfg_data[30:0];
                CFG_RHO:      rho_reg    <= cfg_data[25:0];
                CFG_RHO_COMP: rc_reg     <= cfg_data[24:0];
                CFG_MODE:     mode_reg   <= cfg_data[0];
                CFG_SEG_CNT:  segcnt_reg <= cfg_data[4:0];
                CFG_OBS_CNT:  obscnt_reg <= cfg_data[6:0];
            endcase
        end
    end

    // clamped counts
    logic [6:0] nseg;
    logic [8:0] nobs;
    always_comb begin
        if (segcnt_reg == '0) nseg = 7'd1;
        else if ({2'b0, segcnt_reg} > 7'(MAX_SEGMENTS)) nseg = 7'(MAX_SEGMENTS);
        else nseg = {2'b0, segcnt_reg};
        if (obscnt_reg == '0) nobs = 9'd1;
        else if ({2'b0, obscnt_reg} > 9'(MAX_OBSERVATIONS)) nobs = 9'(MAX_OBSERVATIONS);
        else nobs = {2'b0, obscnt_reg};
    end

    // path state
    logic signed [47:0] price_reg, peak_reg;
    logic signed [31:0] var_reg;
    logic [23:0]        step_reg;
    logic [SAW-1:0]     seg_ptr_reg;
    logic [OPW-1:0]     obs_ptr_reg;
    logic signed [31:0] n1_reg, n2_reg;

    // tables
    logic [23:0]        seg_end_mem [MAX_SEGMENTS];
    logic signed [31:0] seg_lvl_mem [MAX_SEGMENTS];
    logic signed [31:0] seg_vv_mem  [MAX_SEGMENTS];
    logic [23:0]        obs_step_mem [MAX_OBSERVATIONS];
    logic signed [47:0] fwd_mem      [MAX_OBSERVATIONS];
    logic [23:0]        seg_end_rd, obs_step_rd;
    logic signed [31:0] seg_lvl_rd, seg_vv_rd;
    logic signed [47:0] fwd_rd;

    logic signed [31:0] lvl_sat;
    always_comb begin
        if (&s_table_value[47:31] || ~|s_table_value[47:31]) lvl_sat = s_table_value[31:0];
        else lvl_sat = s_table_value[47] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end

    // segment table: load write, read at the current segment
    always_ff @(posedge aclk) begin
        if (s_accept && s_opcode == OP_LOAD_SEG && int'(s_table_index) < MAX_SEGMENTS) begin
            seg_end_mem[SAW'(s_table_index)] <= s_bound_step;
            seg_lvl_mem[SAW'(s_table_index)] <= lvl_sat;
            seg_vv_mem[SAW'(s_table_index)]  <= s_segment_volvol;
        end
        seg_end_rd <= seg_end_mem[seg_ptr_reg];
        seg_lvl_rd <= seg_lvl_mem[seg_ptr_reg];
        seg_vv_rd  <= seg_vv_mem[seg_ptr_reg];
    end

    // observation table: load write, read at the next observation
    always_ff @(posedge aclk) begin
        if (s_accept && s_opcode == OP_LOAD_OBS &&
            int'(s_table_index) < MAX_OBSERVATIONS) begin
            obs_step_mem[OAW'(s_table_index)] <= s_bound_step;
            fwd_mem[OAW'(s_table_index)]      <= s_table_value;
        end
        obs_step_rd <= obs_step_mem[OAW'(obs_ptr_reg)];
        fwd_rd      <= fwd_mem[OAW'(obs_ptr_reg)];
    end

    // step normals
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            n1_reg <= s_normal_first;
            n2_reg <= s_normal_second;
        end
    end

    // product results
    logic signed [47:0] sqdt_reg, p1_reg, p2_reg, a_reg, drift_reg;
    logic signed [47:0] t_reg, diffu_reg, m_reg, ds_reg;

    // state update sums
    logic signed [48:0] price_sum;
    logic signed [49:0] var_sum;
    logic signed [47:0] price_next;
    logic signed [31:0] var_next;
    logic               seg_adv_ok;
    always_comb begin
        price_sum  = 49'(price_reg) + 49'(ds_reg);
        price_next = sat49(price_sum);
        var_sum    = 50'(var_reg) + 50'(drift_reg) + 50'(diffu_reg);
        if (&var_sum[49:31] || ~|var_sum[49:31]) var_next = var_sum[31:0];
        else var_next = var_sum[49] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        seg_adv_ok = (step_reg > seg_end_rd) && (7'(seg_ptr_reg) + 7'd1 < nseg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            price_reg   <= '0;
            peak_reg    <= '0;
            var_reg     <= '0;
            step_reg    <= '0;
            seg_ptr_reg <= '0;
            obs_ptr_reg <= '0;
        end else begin
            if (s_accept && s_opcode == OP_START) begin
                price_reg   <= {1'b0, spot_reg};
                peak_reg    <= {1'b0, spot_reg};
                var_reg     <= {1'b0, ivar_reg};
                step_reg    <= '0;
                seg_ptr_reg <= '0;
                obs_ptr_reg <= '0;
            end
            if (cmd.seg_adv && seg_adv_ok) seg_ptr_reg <= seg_ptr_reg + 1'b1;
            if (cmd.update) begin
                price_reg <= price_next;
                var_reg   <= var_next;
            end
            if (cmd.peak && price_reg > peak_reg) peak_reg <= price_reg;
            if (cmd.step_inc && step_reg != 24'hFF_FFFF) step_reg <= step_reg + 24'd1;
            if (cmd.emit) obs_ptr_reg <= obs_ptr_reg + 1'b1;
        end
    end

    // square root unit: two radicand bits per cycle
    logic [55:0] sx_reg;
    logic [29:0] srem_reg;
    logic [27:0] sroot_reg;
    logic [4:0]  scnt_reg;
    logic        sbusy_reg;
    logic [31:0] s_r2, s_test;
    logic [31:0] var_mag;
    always_comb begin
        var_mag = var_reg[31] ? (~var_reg + 32'd1) : var_reg;
        s_r2    = {srem_reg, sx_reg[55:54]};
        s_test  = {2'b0, sroot_reg, 2'b01};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sbusy_reg <= 1'b0;
            scnt_reg  <= '0;
        end else if (cmd.sqrt_start) begin
            sx_reg    <= {var_mag, 24'b0};
            srem_reg  <= '0;
            sroot_reg <= '0;
            scnt_reg  <= 5'd28;
            sbusy_reg <= 1'b1;
        end else if (sbusy_reg) begin
            if (scnt_reg == '0) begin
                sbusy_reg <= 1'b0;
            end else begin
                sx_reg   <= {sx_reg[53:0], 2'b00};
                scnt_reg <= scnt_reg - 5'd1;
                if (s_r2 >= s_test) begin
                    srem_reg  <= 30'(s_r2 - s_test);
                    sroot_reg <= {sroot_reg[26:0], 1'b1};
                end else begin
                    srem_reg  <= s_r2[29:0];
                    sroot_reg <= {sroot_reg[26:0], 1'b0};
                end
            end
        end
    end

    // shared multiplier operand select
    logic signed [47:0] zc;
    logic signed [32:0] theta_m_v;
    logic [47:0]        op_a, op_b;
    always_comb begin
        zc        = sat49(49'(p1_reg) + 49'(p2_reg));
        theta_m_v = 33'(seg_lvl_rd) - 33'(var_reg);
        unique case (cmd.mul_sel)
            MUL_SQDT: begin op_a = {20'b0, sroot_reg};  op_b = {22'b0, SDT_Q32}; end
            MUL_RN1:  begin op_a = 48'(rho_reg);        op_b = 48'(n1_reg);      end
            MUL_RCN2: begin op_a = {23'b0, rc_reg};     op_b = 48'(n2_reg);      end
            MUL_KAP:  begin op_a = {17'b0, kappa_reg};  op_b = 48'(theta_m_v);   end
            MUL_DT:   begin op_a = a_reg;               op_b = {29'b0, DT_Q32};  end
            MUL_SZ:   begin op_a = sqdt_reg;            op_b = zc;               end
            MUL_XI:   begin op_a = 48'(seg_vv_rd);      op_b = t_reg;            end
            MUL_SN1:  begin op_a = sqdt_reg;            op_b = 48'(n1_reg);      end
            MUL_S:    begin op_a = price_reg;           op_b = m_reg;            end
            MUL_FWD: begin
                op_a = fwd_rd;
                op_b = mode_reg ? peak_reg : price_reg;
            end
            default:  begin op_a = '0;                  op_b = '0;               end
        endcase
    end

    // shared multiplier: four 24x24 partial products, then round and saturate
    logic [47:0] ma_reg, mb_reg;
    logic        mneg_reg, mbusy_reg;
    logic [2:0]  mcnt_reg;
    logic [95:0] macc_reg;
    mul_sel_t    msel_reg;
    logic [47:0] mpp;
    logic [95:0] mpp_sh, mrnd, mq;
    logic [47:0] mcap, mqs, mres;
    logic        mul_last;

    always_comb begin
        mpp = (mcnt_reg[0] ? ma_reg[47:24] : ma_reg[23:0]) *
              (mcnt_reg[1] ? mb_reg[47:24] : mb_reg[23:0]);
        unique case (mcnt_reg[1:0])
            2'd0:    mpp_sh = 96'(mpp);
            2'd3:    mpp_sh = 96'(mpp) << 48;
            default: mpp_sh = 96'(mpp) << 24;
        endcase
        mul_last = mbusy_reg && mcnt_reg == 3'd4;
        if (msel_reg == MUL_SQDT || msel_reg == MUL_DT) begin
            mrnd = macc_reg + (96'd1 << 31);
            mq   = mrnd >> 32;
        end else begin
            mrnd = macc_reg + (96'd1 << 23);
            mq   = mrnd >> 24;
        end
        mcap = mneg_reg ? CAP_NEG : CAP_POS;
        mqs  = (mq > 96'(mcap)) ? mcap : mq[47:0];
        mres = mneg_reg ? (~mqs + 48'd1) : mqs;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mbusy_reg <= 1'b0;
            mcnt_reg  <= '0;
        end else if (cmd.mul_start) begin
            ma_reg    <= mag48(op_a);
            mb_reg    <= mag48(op_b);
            mneg_reg  <= op_a[47] ^ op_b[47];
            msel_reg  <= cmd.mul_sel;
            macc_reg  <= '0;
            mcnt_reg  <= '0;
            mbusy_reg <= 1'b1;
        end else if (mbusy_reg) begin
            if (mul_last) begin
                mbusy_reg <= 1'b0;
            end else begin
                macc_reg <= macc_reg + mpp_sh;
                mcnt_reg <= mcnt_reg + 3'd1;
            end
        end
    end

    // product write back
    always_ff @(posedge aclk) begin
        if (mul_last) begin
            unique case (msel_reg)
                MUL_SQDT: sqdt_reg  <= mres;
                MUL_RN1:  p1_reg    <= mres;
                MUL_RCN2: p2_reg    <= mres;
                MUL_KAP:  a_reg     <= mres;
                MUL_DT:   drift_reg <= mres;
                MUL_SZ:   t_reg     <= mres;
                MUL_XI:   diffu_reg <= mres;
                MUL_SN1:  m_reg     <= mres;
                MUL_S:    ds_reg    <= mres;
                default: ;
            endcase
        end
    end

    // divider: restoring, one product bit per cycle, quotient by spot
    logic [95:0] dnum_reg;
    logic [46:0] drem_reg;
    logic [47:0] dq_reg;
    logic        dovf_reg, dbusy_reg;
    logic [6:0]  dcnt_reg;
    logic [47:0] d_r2, dcap, dmag, dval;
    logic        div_last;
    logic signed [47:0] val_reg;

    always_comb begin
        d_r2     = {drem_reg, dnum_reg[95]};
        div_last = dbusy_reg && dcnt_reg == '0;
        dcap     = mneg_reg ? CAP_NEG : CAP_POS;
        dmag     = (dovf_reg || dq_reg > dcap) ? dcap : dq_reg;
        if (spot_reg == '0) dval = (macc_reg == '0) ? 48'd0 : dcap;
        else dval = mneg_reg ? (~dmag + 48'd1) : dmag;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dbusy_reg <= 1'b0;
            dcnt_reg  <= '0;
        end else if (cmd.div_start) begin
            dnum_reg  <= macc_reg;
            drem_reg  <= '0;
            dq_reg    <= '0;
            dovf_reg  <= 1'b0;
            dcnt_reg  <= 7'd96;
            dbusy_reg <= 1'b1;
        end else if (dbusy_reg) begin
            if (div_last) begin
                dbusy_reg <= 1'b0;
                val_reg   <= dval;
            end else begin
                dnum_reg <= {dnum_reg[94:0], 1'b0};
                dcnt_reg <= dcnt_reg - 7'd1;
                if (dq_reg[47]) dovf_reg <= 1'b1;
                if (d_r2 >= {1'b0, spot_reg}) begin
                    drem_reg <= 47'(d_r2 - {1'b0, spot_reg});
                    dq_reg   <= {dq_reg[46:0], 1'b1};
                end else begin
                    drem_reg <= d_r2[46:0];
                    dq_reg   <= {dq_reg[46:0], 1'b0};
                end
            end
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid <= 1'b0;
        end else if (cmd.emit) begin
            m_valid <= 1'b1;
        end else if (m_ready) begin
            m_valid <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            m_observation_index <= 6'(obs_ptr_reg);
            m_path_value        <= val_reg;
            m_last              <= (9'(obs_ptr_reg) + 9'd1 == nobs);
        end
    end

    // status
    always_comb begin
        sts.path_done = 9'(obs_ptr_reg) >= nobs;
        sts.sqrt_done = sbusy_reg && scnt_reg == '0;
        sts.mul_done  = mul_last;
        sts.div_done  = div_last;
        sts.obs_hit   = step_reg == obs_step_rd;
        sts.out_full  = m_valid && !m_ready;
    end

endmodule

`default_nettype wire

/* hdl/heston_euler_path_step.sv */
// heston euler path step: load, start and time step words; one word at a time.
// load, start and ignored step words need no sequencing. a time step word runs a square root,
// nine products on the shared multiplier, the update and the peak; when it hits an observation
// point, one more product and a divide by spot follow; a stalled result adds its stall.
// synchronous active-low reset clears control and path state; tables hold
// whatever was loaded and read as undefined until written.
`default_nettype none

module heston_euler_path_step #(
    parameter int MAX_SEGMENTS     = 16,
    parameter int MAX_OBSERVATIONS = 64
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               cfg_wr_en,
    input  wire logic [2:0]         cfg_index,
    input  wire logic [46:0]        cfg_data,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [1:0]         s_opcode,
    input  wire logic [5:0]         s_table_index,
    input  wire logic [23:0]        s_bound_step,
    input  wire logic signed [47:0] s_table_value,
    input  wire logic signed [31:0] s_segment_volvol,
    input  wire logic signed [31:0] s_normal_first,
    input  wire logic signed [31:0] s_normal_second,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic [5:0]              m_observation_index,
    output logic signed [47:0]      m_path_value,
    output logic                    m_last
);
    import hes_pkg::*;

    cmd_t cmd;
    sts_t sts;
    logic s_accept;

    assign s_accept = s_valid && s_ready;

    // sequencer
    hes_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_opcode (s_opcode),
        .s_ready  (s_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // datapath
    hes_dp #(
        .MAX_SEGMENTS     (MAX_SEGMENTS),
        .MAX_OBSERVATIONS (MAX_OBSERVATIONS)
    ) u_dp (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .cfg_wr_en           (cfg_wr_en),
        .cfg_index           (cfg_index),
        .cfg_data            (cfg_data),
        .s_accept            (s_accept),
        .s_opcode            (s_opcode),
        .s_table_index       (s_table_index),
        .s_bound_step        (s_bound_step),
        .s_table_value       (s_table_value),
        .s_segment_volvol    (s_segment_volvol),
        .s_normal_first      (s_normal_first),
        .s_normal_second     (s_normal_second),
        .cmd                 (cmd),
        .sts                 (sts),
        .m_ready             (m_ready),
        .m_valid             (m_valid),
        .m_observation_index (m_observation_index),
        .m_path_value        (m_path_value),
        .m_last              (m_last)
    );

endmodule

`default_nettype wire

/* hdl/hes_chk.sv */
// hes_chk: port-level checks for heston_euler_path_step, bound to the top level
// depends on hes_pkg
`default_nettype none

module hes_chk (
    input wire logic               aclk,
    input wire logic               aresetn,
    input wire logic               s_valid,
    input wire logic               s_ready,
    input wire logic [1:0]         s_opcode,
    input wire logic               m_valid,
    input wire logic               m_ready,
    input wire logic signed [47:0] m_path_value
);
    import hes_pkg::*;

    // a stalled result word stays
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> m_valid)
        else $error("result word dropped while stalled");

    // a stalled result word keeps its value
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> $stable(m_path_value))
        else $error("result value changed while stalled");

    // load and start words finish at once
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_opcode != OP_STEP) |=> s_ready)
        else $error("busy after a non-step word");

    // a result never appears right after an accepted word
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> !$past(s_valid && s_ready))
        else $error("result too soon after input");

endmodule

bind heston_euler_path_step hes_chk u_hes_chk (.*);

`default_nettype wire

/* tb/sv/tb_heston_euler_path_step.sv */
// tb_heston_euler_path_step: self-checking testbench for the heston euler path step block
// depends on hes_pkg and heston_euler_path_step; carries its own bit-exact path predictor
`timescale 1ns / 1ps

module tb_heston_euler_path_step;
    import hes_pkg::*;

    localparam longint PRICE_CAP  = 64'h7FFF_FFFF_FFFF;
    localparam longint VAR_CAP    = 64'h7FFF_FFFF;
    localparam longint Q24_ONE    = 64'd16777216;
    localparam longint SQRT_DT    = 64'd42949673;
    localparam longint DT_STEP    = 64'd429497;
    localparam int     SEG_DEPTH  = 16;
    localparam int     OBS_DEPTH  = 64;
    localparam int     WORD_GOAL  = 2000;
    localparam int     HANG_LIMIT = 20000;
    localparam int     DRAIN_WAIT = 250;

    typedef struct {
        opcode_t            op;
        logic [5:0]         idx;
        logic [23:0]        bound;
        logic signed [47:0] tval;
        logic signed [31:0] volvol;
        logic signed [31:0] n1;
        logic signed [31:0] n2;
    } path_word_t;

    typedef struct {
        logic [5:0]  idx;
        logic [47:0] value;
        logic        last;
    } obs_word_t;

    typedef struct {
        logic [46:0]        spot;
        logic [30:0]        v0;
        logic [30:0]        kappa;
        logic signed [25:0] rho;
        logic [24:0]        rho_comp;
        logic               mode;
        logic [4:0]         nseg;
        logic [6:0]         nobs;
    } heston_cfg_t;

    logic               aclk;
    logic               aresetn;
    logic               cfg_wr_en;
    logic [2:0]         cfg_index;
    logic [46:0]        cfg_data;
    logic               s_valid;
    logic               s_ready;
    logic [1:0]         s_opcode;
    logic [5:0]         s_table_index;
    logic [23:0]        s_bound_step;
    logic signed [47:0] s_table_value;
    logic signed [31:0] s_segment_volvol;
    logic signed [31:0] s_normal_first;
    logic signed [31:0] s_normal_second;
    logic               m_valid;
    logic               m_ready;
    logic [5:0]         m_observation_index;
    logic signed [47:0] m_path_value;
    logic               m_last;

    heston_euler_path_step DUT (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .cfg_wr_en           (cfg_wr_en),
        .cfg_index           (cfg_index),
        .cfg_data            (cfg_data),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_opcode            (s_opcode),
        .s_table_index       (s_table_index),
        .s_bound_step        (s_bound_step),
        .s_table_value       (s_table_value),
        .s_segment_volvol    (s_segment_volvol),
        .s_normal_first      (s_normal_first),
        .s_normal_second     (s_normal_second),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_observation_index (m_observation_index),
        .m_path_value        (m_path_value),
        .m_last              (m_last)
    );

    // predictor copy of registers, path state and tables
    heston_cfg_t        cur_cfg;
    logic signed [47:0] price_q;
    logic signed [47:0] peak_q;
    logic signed [31:0] var_q;
    logic [23:0]        step_cnt;
    logic [4:0]         seg_ptr;
    logic [6:0]         obs_ptr;
    logic [23:0]        seg_end[SEG_DEPTH];
    logic signed [31:0] seg_level[SEG_DEPTH];
    logic signed [31:0] seg_volvol[SEG_DEPTH];
    logic [23:0]        obs_step[OBS_DEPTH];
    logic signed [47:0] obs_forward[OBS_DEPTH];

    obs_word_t expected_obs[$];
    int words_sent;
    int obs_checked;
    int mismatches;
    int idle_cycles;
    int rx_stall;
    bit tx_bursts;
    bit rx_bursts;

    // clock
    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // ---------------- fixed point helpers ----------------

    function automatic longint clamp_to(longint v, longint lim);
        if (v > lim) return lim;
        if (v < -lim - 1) return -lim - 1;
        return v;
    endfunction

    // round(a*b / 2^sh) half away from zero, saturated
    function automatic longint q_mul(longint a, longint b, int sh, longint lim);
        logic signed [127:0] pa, pb, p;
        logic [127:0] m, q, cap;
        logic neg;
        pa = a;
        pb = b;
        p = pa * pb;
        neg = (a < 0) != (b < 0);
        m = p[127] ? -p : p;
        q = (m + (128'd1 << (sh - 1))) >> sh;
        cap = neg ? 128'(lim) + 128'd1 : 128'(lim);
        if (q > cap) q = cap;
        return neg ? -longint'(q[63:0]) : longint'(q[63:0]);
    endfunction

    function automatic logic [63:0] root_floor(logic [63:0] x);
        logic [63:0] r, b;
        r = '0;
        b = 64'd1 << 62;
        while (b > x) b = b >> 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // trunc(f*x / spot), saturated to 48-bit signed
    function automatic longint scaled_quotient(longint f, longint x, logic [46:0] d);
        logic signed [127:0] pf, px, p;
        logic [127:0] m, q, cap;
        logic neg;
        pf = f;
        px = x;
        p = pf * px;
        neg = (f < 0) != (x < 0);
        m = p[127] ? -p : p;
        cap = neg ? 128'(PRICE_CAP) + 128'd1 : 128'(PRICE_CAP);
        if (d == 0) begin
            if (m == 0) return 0;
            q = cap;
        end else begin
            q = m / {81'd0, d};
        end
        if (q > cap) q = cap;
        return neg ? -longint'(q[63:0]) : longint'(q[63:0]);
    endfunction

    // ---------------- path predictor ----------------

    task automatic predict_path_word(path_word_t w);
        int nseg, nobs;
        longint theta, xi, vnow, sq, sqdt, zc, drift, diffu, pnext, val;
        obs_word_t r;
        case (w.op)
            OP_LOAD_SEG: begin
                if (w.idx < SEG_DEPTH) begin
                    seg_end[w.idx]    = w.bound;
                    seg_level[w.idx]  = 32'(clamp_to(longint'(w.tval), VAR_CAP));
                    seg_volvol[w.idx] = w.volvol;
                end
            end
            OP_LOAD_OBS: begin
                obs_step[w.idx]    = w.bound;
                obs_forward[w.idx] = w.tval;
            end
            OP_START: begin
                price_q  = 48'(cur_cfg.spot);
                peak_q   = 48'(cur_cfg.spot);
                var_q    = 32'(cur_cfg.v0);
                step_cnt = '0;
                seg_ptr  = '0;
                obs_ptr  = '0;
            end
            default: begin
                nseg = (cur_cfg.nseg < 1) ? 1 : int'(cur_cfg.nseg);
                if (nseg > SEG_DEPTH) nseg = SEG_DEPTH;
                nobs = (cur_cfg.nobs < 1) ? 1 : int'(cur_cfg.nobs);
                if (nobs > OBS_DEPTH) nobs = OBS_DEPTH;
                // path complete: step words are ignored
                if (obs_ptr < nobs) begin
                    if (step_cnt > seg_end[seg_ptr] && int'(seg_ptr) + 1 < nseg)
                        seg_ptr = seg_ptr + 5'd1;
                    theta = seg_level[seg_ptr];
                    xi    = seg_volvol[seg_ptr];
                    vnow  = var_q;
                    sq    = longint'(root_floor(64'((vnow < 0) ? -vnow : vnow) << 24));
                    sqdt  = q_mul(sq, SQRT_DT, 32, PRICE_CAP);
                    zc    = clamp_to(q_mul(cur_cfg.rho, w.n1, 24, PRICE_CAP)
                                     + q_mul(longint'(cur_cfg.rho_comp), w.n2, 24, PRICE_CAP),
                                     PRICE_CAP);
                    drift = q_mul(q_mul(longint'(cur_cfg.kappa), theta - vnow, 24, PRICE_CAP),
                                  DT_STEP, 32, PRICE_CAP);
                    diffu = q_mul(xi, q_mul(sqdt, zc, 24, PRICE_CAP), 24, PRICE_CAP);
                    pnext = clamp_to(longint'(price_q)
                                     + q_mul(price_q, q_mul(sqdt, w.n1, 24, PRICE_CAP),
                                             24, PRICE_CAP), PRICE_CAP);
                    price_q = 48'(pnext);
                    var_q   = 32'(clamp_to(vnow + drift + diffu, VAR_CAP));
                    if (price_q > peak_q) peak_q = price_q;
                    if (step_cnt == obs_step[obs_ptr]) begin
                        val = scaled_quotient(obs_forward[obs_ptr],
                                              cur_cfg.mode ? peak_q : price_q, cur_cfg.spot);
                        r.idx   = 6'(obs_ptr);
                        r.value = 48'(val);
                        r.last  = (int'(obs_ptr) + 1 == nobs);
                        expected_obs.push_back(r);
                        obs_ptr = obs_ptr + 7'd1;
                    end
                    if (step_cnt != 24'hFF_FFFF) step_cnt = step_cnt + 24'd1;
                end
            end
        endcase
    endtask

    // ---------------- drivers ----------------

    task automatic send_word(path_word_t w);
        if (tx_bursts && $urandom_range(0, 5) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge aclk);
        end
        s_valid          <= 1'b1;
        s_opcode         <= w.op;
        s_table_index    <= w.idx;
        s_bound_step     <= w.bound;
        s_table_value    <= w.tval;
        s_segment_volvol <= w.volvol;
        s_normal_first   <= w.n1;
        s_normal_second  <= w.n2;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_path_word(w);
        words_sent++;
    endtask

    // hold the sender until every expected word is out, then let the block finish
    task automatic drain_block();
        s_valid <= 1'b0;
        while (expected_obs.size() != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
    endtask

    task automatic write_config(heston_cfg_t c);
        logic [46:0] d;
        for (int i = 0; i < 8; i++) begin
            case (cfg_idx_t'(i))
                CFG_SPOT:     d = c.spot;
                CFG_INIT_VAR: d = 47'(c.v0);
                CFG_KAPPA:    d = 47'(c.kappa);
                CFG_RHO:      d = 47'(c.rho);
                CFG_RHO_COMP: d = 47'(c.rho_comp);
                CFG_MODE:     d = 47'(c.mode);
                CFG_SEG_CNT:  d = 47'(c.nseg);
                default:      d = 47'(c.nobs);
            endcase
            cfg_wr_en <= 1'b1;
            cfg_index <= 3'(i);
            cfg_data  <= d;
            @(posedge aclk);
        end
        cfg_wr_en <= 1'b0;
        cur_cfg = c;
    endtask

    function automatic path_word_t make_word(opcode_t op, int idx, longint bound,
                                             longint tval, longint vv,
                                             longint n1, longint n2);
        path_word_t w;
        w.op     = op;
        w.idx    = 6'(idx);
        w.bound  = 24'(bound);
        w.tval   = 48'(tval);
        w.volvol = 32'(vv);
        w.n1     = 32'(n1);
        w.n2     = 32'(n2);
        return w;
    endfunction

    function automatic longint rand_normal();
        if ($urandom_range(0, 15) == 0) return longint'(signed'($urandom));
        return longint'($urandom_range(0, 100663296)) - 3 * Q24_ONE;
    endfunction

    function automatic longint rand_wide();
        return longint'({$urandom, $urandom}) >>> 16;
    endfunction

    function automatic heston_cfg_t rand_config();
        heston_cfg_t c;
        if ($urandom_range(0, 9) == 0) c.spot = 47'({$urandom, $urandom});
        else c.spot = 47'(longint'($urandom_range(1, 200)) * Q24_ONE
                          + $urandom_range(0, 16777215));
        c.v0       = 31'($urandom_range(0, 8388608));
        c.kappa    = 31'($urandom_range(0, 83886080));
        c.rho      = 26'(int'($urandom_range(0, 33554432)) - 16777216);
        c.rho_comp = 25'($urandom_range(0, 16777216));
        c.mode     = 1'($urandom_range(0, 1));
        c.nseg     = ($urandom_range(0, 7) == 0) ? 5'($urandom_range(0, 31))
                                                 : 5'($urandom_range(1, 16));
        c.nobs     = ($urandom_range(0, 14) == 0) ? 7'($urandom_range(11, 127))
                                                  : 7'($urandom_range(1, 10));
        return c;
    endfunction

    // ---------------- tests ----------------

    // every table entry gets a value so no step can read an unwritten entry
    task automatic test_table_fill();
        for (int i = 0; i < SEG_DEPTH; i++)
            send_word(make_word(OP_LOAD_SEG, i, 2 * i, 671089, 8388608, 0, 0));
        for (int i = 0; i < OBS_DEPTH; i++)
            send_word(make_word(OP_LOAD_OBS, i, i, Q24_ONE, 0, 0, 0));
    endtask

    // registers at their top ends, level too wide, ignored loads, path complete
    task automatic test_extremes();
        heston_cfg_t c;
        c = '{spot: '1, v0: '1, kappa: '1, rho: -26'sd16777216, rho_comp: 25'd16777216,
              mode: 1'b1, nseg: 5'd31, nobs: 7'd0};
        drain_block();
        write_config(c);
        send_word(make_word(OP_LOAD_SEG, 40, 24'hFF_FFFF, -1, -1, 0, 0));
        send_word(make_word(OP_LOAD_SEG, 0, 0, PRICE_CAP, -64'sd2147483648, 0, 0));
        send_word(make_word(OP_LOAD_SEG, 1, 24'hFF_FFFF, -PRICE_CAP - 1, VAR_CAP, 0, 0));
        send_word(make_word(OP_LOAD_OBS, 0, 0, PRICE_CAP, 0, 0, 0));
        send_word(make_word(OP_START, 63, 0, 0, 0, 0, 0));
        send_word(make_word(OP_STEP, 0, 0, 0, 0, VAR_CAP, -VAR_CAP - 1));
        send_word(make_word(OP_STEP, 0, 0, 0, 0, -VAR_CAP - 1, VAR_CAP));
    endtask

    // zero spot, zero rates, clamped segment count, negative forwards
    task automatic test_zero_spot();
        heston_cfg_t c;
        c = '{spot: '0, v0: '0, kappa: '0, rho: 26'sd16777216, rho_comp: '0,
              mode: 1'b0, nseg: 5'd0, nobs: 7'd3};
        drain_block();
        write_config(c);
        send_word(make_word(OP_LOAD_OBS, 0, 0, Q24_ONE, 0, 0, 0));
        send_word(make_word(OP_LOAD_OBS, 1, 1, -PRICE_CAP - 1, 0, 0, 0));
        send_word(make_word(OP_LOAD_OBS, 2, 2, 0, 0, 0, 0));
        send_word(make_word(OP_START, 0, 0, 0, 0, 0, 0));
        for (int k = 0; k < 4; k++)
            send_word(make_word(OP_STEP, 0, 0, 0, 0, VAR_CAP, 0));
    endtask

    // observation count beyond the table and a restart in the middle of a path
    task automatic test_restart();
        heston_cfg_t c;
        c = '{spot: 47'(100 * Q24_ONE), v0: 31'd671089, kappa: 31'(2 * Q24_ONE),
              rho: -26'sd11744051, rho_comp: 25'd11981281, mode: 1'b0,
              nseg: 5'd16, nobs: 7'd127};
        drain_block();
        write_config(c);
        for (int i = 0; i < 3; i++)
            send_word(make_word(OP_LOAD_OBS, i, i, Q24_ONE, 0, 0, 0));
        send_word(make_word(OP_START, 0, 0, 0, 0, 0, 0));
        send_word(make_word(OP_STEP, 0, 0, 0, 0, Q24_ONE, -Q24_ONE));
        send_word(make_word(OP_START, 0, 0, 0, 0, 0, 0));
        send_word(make_word(OP_STEP, 0, 0, 0, 0, -Q24_ONE, Q24_ONE));
    endtask

    task automatic send_noise();
        send_word(make_word(opcode_t'($urandom_range(0, 2)), $urandom_range(0, 63),
                            $urandom, rand_wide(), signed'($urandom),
                            signed'($urandom), signed'($urandom)));
    endtask

    // well-formed paths with random content, some noise between the loads
    task automatic test_random_paths();
        heston_cfg_t c;
        int nseg, nobs, bound, last_obs;
        while (words_sent < WORD_GOAL) begin
            if (words_sent > WORD_GOAL - 300) begin
                tx_bursts = 1'b0;
                rx_bursts = 1'b0;
            end
            c = rand_config();
            drain_block();
            write_config(c);
            nseg = (c.nseg < 1) ? 1 : ((c.nseg > SEG_DEPTH) ? SEG_DEPTH : int'(c.nseg));
            nobs = (c.nobs < 1) ? 1 : ((c.nobs > OBS_DEPTH) ? OBS_DEPTH : int'(c.nobs));
            bound = 0;
            for (int i = 0; i < nseg; i++) begin
                bound += $urandom_range(0, 6);
                send_word(make_word(OP_LOAD_SEG, i, bound,
                                    $urandom_range(0, 16777216), rand_normal() / 4, 0, 0));
                if ($urandom_range(0, 11) == 0) send_noise();
            end
            last_obs = -1;
            for (int i = 0; i < nobs; i++) begin
                last_obs += 1 + $urandom_range(0, 3);
                send_word(make_word(OP_LOAD_OBS, i, last_obs,
                                    ($urandom_range(0, 9) == 0) ? rand_wide()
                                    : longint'($urandom_range(4194304, 67108864)), 0, 0, 0));
                if ($urandom_range(0, 11) == 0) send_noise();
            end
            send_word(make_word(OP_START, 0, 0, 0, 0, 0, 0));
            for (int k = 0; k <= last_obs + int'($urandom_range(0, 2)); k++)
                send_word(make_word(OP_STEP, 0, 0, 0, 0, rand_normal(), rand_normal()));
        end
    endtask

    // ---------------- result side ----------------

    // random stall bursts on the result channel
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready  <= 1'b1;
            rx_stall <= 0;
        end else if (rx_stall > 0) begin
            rx_stall <= rx_stall - 1;
            m_ready  <= (rx_stall == 1);
        end else if (rx_bursts && $urandom_range(0, 7) == 0) begin
            rx_stall <= $urandom_range(1, 8);
            m_ready  <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // compare each observation word with the oldest prediction
    always @(posedge aclk) begin
        obs_word_t e;
        if (aresetn && m_valid && m_ready) begin
            if (expected_obs.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word: index %0d value %0d last %0b",
                             m_observation_index, m_path_value, m_last);
            end else begin
                e = expected_obs.pop_front();
                obs_checked++;
                if (m_observation_index !== e.idx || m_path_value !== e.value
                    || m_last !== e.last) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected index %0d value %0d last %0b, got %0d %0d %0b",
                                 e.idx, $signed(e.value), e.last,
                                 m_observation_index, m_path_value, m_last);
                end
            end
        end
    end

    // hang detection
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles == HANG_LIMIT) begin
            $display("timeout with %0d words outstanding", expected_obs.size());
            $display("tb_heston_euler_path_step NOT OK");
            $finish;
        end
    end

    // ---------------- sequence ----------------

    initial begin
        aresetn          = 1'b0;
        cfg_wr_en        = 1'b0;
        cfg_index        = '0;
        cfg_data         = '0;
        s_valid          = 1'b0;
        s_opcode         = '0;
        s_table_index    = '0;
        s_bound_step     = '0;
        s_table_value    = '0;
        s_segment_volvol = '0;
        s_normal_first   = '0;
        s_normal_second  = '0;
        cur_cfg = '{spot: 47'(Q24_ONE), v0: '0, kappa: '0, rho: '0,
                    rho_comp: 25'd16777216, mode: 1'b0, nseg: 5'd1, nobs: 7'd1};
        price_q  = '0;
        peak_q   = '0;
        var_q    = '0;
        step_cnt = '0;
        seg_ptr  = '0;
        obs_ptr  = '0;
        words_sent  = 0;
        obs_checked = 0;
        mismatches  = 0;
        tx_bursts   = 1'b1;
        rx_bursts   = 1'b1;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_table_fill();
        test_extremes();
        test_zero_spot();
        test_restart();
        test_random_paths();

        drain_block();
        $display("sent %0d words over directed corners and random heston paths", words_sent);
        $display("checked %0d observation words, %0d mismatches", obs_checked, mismatches);
        if (mismatches == 0 && expected_obs.size() == 0) begin
            $display("tb_heston_euler_path_step OK");
        end else begin
            $display("tb_heston_euler_path_step NOT OK");
        end
        $finish;
    end

endmodule

/* filelist.f */
hdl/hes_pkg.sv
hdl/hes_ctrl.sv
hdl/hes_dp.sv
hdl/heston_euler_path_step.sv
hdl/hes_chk.sv
tb/sv/tb_heston_euler_path_step.sv
